>>> sv/ldfs_pkg.sv
package ldfs_pkg;

   localparam int MaxDevices = 8;
   localparam int FrameBits = 16;
   localparam int DevCountWidth = 4;
   localparam int DevIndexWidth = $clog2(MaxDevices) > 0 ? $clog2(MaxDevices) : 1;
   localparam int QueueDepth = 4;
   localparam int QueueAddrWidth = $clog2(QueueDepth);
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 8;

   // Request kinds carried in req_type.
   typedef enum logic [2:0] {
      REQ_SEND_ONE = 3'd0,
      REQ_SEND_ALL = 3'd1,
      REQ_REFRESH  = 3'd2,
      REQ_CLEAR    = 3'd3,
      REQ_LATCH    = 3'd4
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DECODE_MODE  = 3'd0,
      CSR_BRIGHTNESS   = 3'd1,
      CSR_SCAN_DIGITS  = 3'd2,
      CSR_POWER_ON     = 3'd3,
      CSR_TEST_MODE    = 3'd4,
      CSR_DEVICE_COUNT = 3'd5
   } csr_index_type;

   // Driver register addresses.
   localparam logic [7:0] ADDR_DIGIT0    = 8'd1;
   localparam logic [7:0] ADDR_DECODE    = 8'd9;
   localparam logic [7:0] ADDR_INTENSITY = 8'd10;
   localparam logic [7:0] ADDR_SCAN      = 8'd11;
   localparam logic [7:0] ADDR_SHUTDOWN  = 8'd12;
   localparam logic [7:0] ADDR_TEST      = 8'd15;

   localparam logic [2:0] REFRESH_LAST_STEP = 3'd4;
   localparam logic [2:0] CLEAR_LAST_STEP   = 3'd7;

   typedef struct packed {
      logic [7:0]               decode_mode;
      logic [3:0]               brightness;
      logic [2:0]               scan_digits;
      logic                     power_on;
      logic                     test_mode;
      logic [DevCountWidth-1:0] device_count;
   } cfg_type;

   // One command for the back end: either a single frame (or bare latch),
   // or a frame broadcast once per chained device followed by a latch.
   typedef struct packed {
      logic                 frame_valid;
      logic [FrameBits-1:0] word;
      logic                 all;
      logic                 latch;
      logic                 last;
   } group_type;

endpackage

>>> sv/ldfs_front.sv
module ldfs_front
   import ldfs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [2:0]      req_type,
   input  logic [3:0]      req_reg_addr,
   input  logic [7:0]      req_value,
   input  logic            req_latch_now,
   input  cfg_type         cfg,
   output logic            push,
   output group_type       push_group,
   input  logic            queue_full
);

   logic         busy_ff, busy_in;
   req_kind_type kind_ff, kind_in;
   logic [3:0]   addr_ff, addr_in;
   logic [7:0]   value_ff, value_in;
   logic         latch_ff, latch_in;
   logic [2:0]   step_ff, step_in;
   logic         accept;
   logic         group_last;
   logic         known;

   always_comb begin
      push_group = '0;
      group_last = 1'b1;
      unique case (kind_ff)
         REQ_SEND_ONE: begin
            push_group.frame_valid = 1'b1;
            push_group.word = {4'd0, addr_ff, value_ff};
            push_group.latch = latch_ff;
         end
         REQ_SEND_ALL: begin
            push_group.frame_valid = 1'b1;
            push_group.word = {4'd0, addr_ff, value_ff};
            push_group.all = 1'b1;
         end
         REQ_REFRESH: begin
            push_group.frame_valid = 1'b1;
            push_group.all = 1'b1;
            group_last = (step_ff == REFRESH_LAST_STEP);
            case (step_ff)
               3'd0:    push_group.word = {ADDR_DECODE, cfg.decode_mode};
               3'd1:    push_group.word = {ADDR_SCAN, 5'd0, cfg.scan_digits};
               3'd2:    push_group.word = {ADDR_INTENSITY, 4'd0, cfg.brightness};
               3'd3:    push_group.word = {ADDR_SHUTDOWN, 7'd0, cfg.power_on};
               default: push_group.word = {ADDR_TEST, 7'd0, cfg.test_mode};
            endcase
         end
         REQ_CLEAR: begin
            push_group.frame_valid = 1'b1;
            push_group.all = 1'b1;
            push_group.word = {ADDR_DIGIT0 + {5'd0, step_ff}, 8'd0};
            group_last = (step_ff == CLEAR_LAST_STEP);
         end
         REQ_LATCH: begin
            push_group.latch = 1'b1;
         end
         default: begin
            push_group = '0;
         end
      endcase
      push_group.last = group_last;
   end

   assign push = busy_ff && !queue_full;
   assign req_ready = !busy_ff || (push && group_last);
   assign accept = req_valid && req_ready;

   always_comb begin
      known = 1'b0;
      unique case (req_type) inside
         REQ_SEND_ONE, REQ_SEND_ALL, REQ_REFRESH, REQ_CLEAR, REQ_LATCH: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      value_in = value_ff;
      latch_in = latch_ff;
      step_in = step_ff;
      if (push) begin
         step_in = step_ff + 3'd1;
         if (group_last) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in = known;
         kind_in = req_kind_type'(req_type);
         addr_in = req_reg_addr;
         value_in = req_value;
         latch_in = req_latch_now;
         step_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      value_ff <= value_in;
      latch_ff <= latch_in;
   end

endmodule

>>> sv/ldfs_queue.sv
module ldfs_queue
   import ldfs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_group,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output group_type head_group
);

   group_type                 mem_ff [QueueDepth];
   logic [QueueAddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueAddrWidth:0]   count_ff, count_in;

   assign full = (count_ff == QueueAddrWidth'(0) + (QueueAddrWidth+1)'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_group = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

>>> sv/ldfs_back.sv
module ldfs_back
   import ldfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [DevCountWidth-1:0] device_count,
   input  logic                     head_valid,
   input  group_type                head_group,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_frame_valid,
   output logic [FrameBits-1:0]     rsp_frame_word,
   output logic                     rsp_latch_after,
   output logic                     rsp_last
);

   logic [DevIndexWidth-1:0] dev_ff, dev_in;
   logic                     valid_ff, valid_in;
   logic                     fv_ff, fv_in;
   logic [FrameBits-1:0]     word_ff, word_in;
   logic                     latch_ff, latch_in;
   logic                     last_ff, last_in;
   logic [DevCountWidth-1:0] dev_total;
   logic                     no_devices;
   logic                     group_done;
   logic                     load;

   always_comb begin
      if (device_count > DevCountWidth'(MaxDevices)) begin
         dev_total = DevCountWidth'(MaxDevices);
      end else begin
         dev_total = device_count;
      end
      no_devices = (dev_total == '0);
      group_done = !head_group.all || no_devices ||
                   (DevCountWidth'(dev_ff) == dev_total - 1'b1);
      load = head_valid && (!valid_ff || rsp_ready);
      pop = load && group_done;
   end

   always_comb begin
      valid_in = valid_ff;
      fv_in = fv_ff;
      word_in = word_ff;
      latch_in = latch_ff;
      last_in = last_ff;
      dev_in = dev_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         last_in = head_group.last && group_done;
         if (head_group.all) begin
            fv_in = !no_devices;
            word_in = no_devices ? '0 : head_group.word;
            latch_in = group_done;
         end else begin
            fv_in = head_group.frame_valid;
            word_in = head_group.word;
            latch_in = head_group.latch;
         end
         dev_in = group_done ? '0 : dev_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dev_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         dev_ff <= dev_in;
      end
      fv_ff <= fv_in;
      word_ff <= word_in;
      latch_ff <= latch_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_valid = fv_ff;
   assign rsp_frame_word = word_ff;
   assign rsp_latch_after = latch_ff;
   assign rsp_last = last_ff;

endmodule

>>> sv/led_driver_chain_frame_sequencer.sv
// Frame sequencer for a daisy chain of 8-digit LED driver chips. Each request
// transfer is expanded into 16-bit frames (driver register address in bits
// 15..8, data in bits 7..0) with a flag telling the shifter to pulse chip
// select afterwards and a flag marking the last frame of the request. A
// broadcast repeats its frame once per chained device (device count saturates
// at eight) and latches after the final copy; with a device count of zero it
// yields one bare latch. Refresh broadcasts decode mode, scan limit,
// intensity, shutdown and display test in that order; clear broadcasts zero
// to the eight digit registers; request codes five to seven are accepted and
// dropped. The front end splits a request into at most eight broadcast groups
// at one group per cycle while the queue is not full, and the back end emits
// one response transfer per cycle while rsp_ready is high, so the rate is one
// frame per clock, limited by the output register; a new request is taken
// while earlier groups are still waiting in the four-entry queue.
// Configuration registers are written through the csr port and must only be
// changed while no request is in flight.
module led_driver_chain_frame_sequencer
   import ldfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_type,
   input  logic [3:0]               req_reg_addr,
   input  logic [7:0]               req_value,
   input  logic                     req_latch_now,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_frame_valid,
   output logic [FrameBits-1:0]     rsp_frame_word,
   output logic                     rsp_latch_after,
   output logic                     rsp_last,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   group_type push_group;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   group_type head_group;

   // Configuration registers; writes to unused indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DECODE_MODE:  cfg_in.decode_mode = csr_wdata;
            CSR_BRIGHTNESS:   cfg_in.brightness = csr_wdata[3:0];
            CSR_SCAN_DIGITS:  cfg_in.scan_digits = csr_wdata[2:0];
            CSR_POWER_ON:     cfg_in.power_on = csr_wdata[0];
            CSR_TEST_MODE:    cfg_in.test_mode = csr_wdata[0];
            CSR_DEVICE_COUNT: cfg_in.device_count = csr_wdata[DevCountWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode <= 8'd0;
         cfg_ff.brightness <= 4'd0;
         cfg_ff.scan_digits <= 3'd7;
         cfg_ff.power_on <= 1'b0;
         cfg_ff.test_mode <= 1'b0;
         cfg_ff.device_count <= DevCountWidth'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts a request and breaks it into groups.
   ldfs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_reg_addr  (req_reg_addr),
      .req_value     (req_value),
      .req_latch_now (req_latch_now),
      .cfg           (cfg_ff),
      .push          (push),
      .push_group    (push_group),
      .queue_full    (queue_full)
   );

   // Short queue that lets the two halves stall independently.
   ldfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   // Back end: repeats each broadcast group once per device into the output register.
   ldfs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .device_count    (cfg_ff.device_count),
      .head_valid      (head_valid),
      .head_group      (head_group),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_valid (rsp_frame_valid),
      .rsp_frame_word  (rsp_frame_word),
      .rsp_latch_after (rsp_latch_after),
      .rsp_last        (rsp_last)
   );

endmodule
